/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs while reset is held
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/whp_pkg.sv */
// ----------------------------------------------------------------------------
// whp_pkg
// Types, codes and helpers shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package whp_pkg;

    // Default depth of the queue between parser and output stage
    localparam int WHP_QUEUE_DEPTH = 4;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int FMT_W    = 2;
    localparam int ERR_W    = 3;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int OUT_TDATA_W = 80;

    // Input operation codes (carried on tuser)
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // Chunk constants
    localparam logic [WORD_W-1:0] DATA_ID      = 32'h6174_6164;
    localparam logic [WORD_W-1:0] FMT_BASE_LEN = 32'd16;
    localparam logic [WORD_W-1:0] PCM_TAG      = 32'd1;
    localparam logic [HALF_W-1:0] DEPTH_8      = 16'd8;
    localparam logic [HALF_W-1:0] DEPTH_16     = 16'd16;
    localparam logic [HALF_W-1:0] CHAN_MONO    = 16'd1;
    localparam logic [HALF_W-1:0] CHAN_STEREO  = 16'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_FORMAT = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NOT_RIFF     = 3'd0,
        ERR_BAD_FMT      = 3'd1,
        ERR_NOT_PCM      = 3'd2,
        ERR_UNSUPPORTED  = 3'd3,
        ERR_HDR_TRUNC    = 3'd4,
        ERR_NO_DATA      = 3'd5,
        ERR_DATA_TRUNC   = 3'd6
    } t_err;

    // Parse phases, in stream order; range tests rely on this order
    typedef enum logic [3:0] {
        PH_RIFF       = 4'd0,
        PH_FMT_MAGIC  = 4'd1,
        PH_FMT_SIZE   = 4'd2,
        PH_TAG        = 4'd3,
        PH_CHANNELS   = 4'd4,
        PH_RATE       = 4'd5,
        PH_SKIP6      = 4'd6,
        PH_BITS       = 4'd7,
        PH_EXT        = 4'd8,
        PH_CHUNK_ID   = 4'd9,
        PH_SIZE_DATA  = 4'd10,
        PH_SIZE_OTHER = 4'd11,
        PH_SKIP_BODY  = 4'd12,
        PH_DATA       = 4'd13,
        PH_DONE       = 4'd14,
        PH_FAILED     = 4'd15
    } t_phase;

    // One result item
    typedef struct packed {
        t_kind             kind;
        logic [FMT_W-1:0]  sample_format;
        logic [WORD_W-1:0] sample_rate;
        logic [WORD_W-1:0] data_length;
        logic [BYTE_W-1:0] audio_byte;
        logic              is_last;
        t_err              error_code;
    } t_result;

    // Master tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        t_err              error_code;
        logic [BYTE_W-1:0] audio_byte;
        logic [WORD_W-1:0] data_length;
        logic [WORD_W-1:0] sample_rate;
        logic [FMT_W-1:0]  sample_format;
    } t_out_tdata;

    // Queue status seen by the output stage
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [BYTE_W-1:0] riff_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = 8'h52;
            2'd1:    b = 8'h49;
            2'd2:    b = 8'h46;
            default: b = 8'h46;
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] fmt_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = 8'h66;
            2'd1:    b = 8'h6D;
            2'd2:    b = 8'h74;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

    // Little-endian byte insert; byte 0 starts a fresh field
    function automatic logic [WORD_W-1:0] shift_in(input logic [WORD_W-1:0] acc,
                                                  input logic [1:0] idx,
                                                  input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] v;
        case (idx)
            2'd0:    v = {24'd0, b};
            2'd1:    v = {acc[31:16], b, acc[7:0]};
            2'd2:    v = {acc[31:24], b, acc[15:0]};
            default: v = {b, acc[23:0]};
        endcase
        return v;
    endfunction

    function automatic t_result make_error(input t_err code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

/* hw/rtl/whp_front.sv */
// ----------------------------------------------------------------------------
// whp_front
// Byte-wise RIFF/WAVE header walker; produces at most one result per byte.
// ----------------------------------------------------------------------------
module whp_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_op,
    input  logic [whp_pkg::BYTE_W-1:0] i_byte,
    output logic                      o_push,
    output whp_pkg::t_result          o_result
);
    import whp_pkg::*;

    t_phase            r_phase,   n_phase;
    logic [3:0]        r_cnt,     n_cnt;
    logic [WORD_W-1:0] r_shift,   n_shift;
    logic [WORD_W-1:0] r_fmt_len, n_fmt_len;
    logic [HALF_W-1:0] r_chan,    n_chan;
    logic [HALF_W-1:0] r_bits,    n_bits;
    logic [WORD_W-1:0] r_rate,    n_rate;
    logic [WORD_W-1:0] r_remain,  n_remain;

    logic [1:0]        idx;
    logic [WORD_W-1:0] shifted;
    logic [3:0]        cnt_take;
    logic              remain_last;
    logic [WORD_W-1:0] remain_dec;
    logic              bad_format;

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RIFF;
            r_cnt     <= '0;
            r_shift   <= '0;
            r_fmt_len <= '0;
            r_chan    <= '0;
            r_bits    <= '0;
            r_rate    <= '0;
            r_remain  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_shift   <= n_shift;
            r_fmt_len <= n_fmt_len;
            r_chan    <= n_chan;
            r_bits    <= n_bits;
            r_rate    <= n_rate;
            r_remain  <= n_remain;
        end
    end

    // Shared field helpers
    always_comb begin
        idx         = r_cnt[1:0];
        shifted     = shift_in(r_shift, idx, i_byte);
        cnt_take    = {2'b00, idx + 2'd1};
        remain_last = (r_remain == 32'd1);
        remain_dec  = r_remain - 32'd1;
        bad_format  = ((shifted[15:0] != DEPTH_8) && (shifted[15:0] != DEPTH_16)) ||
                      ((r_chan != CHAN_MONO) && (r_chan != CHAN_STEREO));
    end

    // Advance the parse phase on each accepted transfer
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_fmt_len = r_fmt_len;
        n_chan    = r_chan;
        n_bits    = r_bits;
        n_rate    = r_rate;
        n_remain  = r_remain;
        o_push    = 1'b0;
        o_result  = '0;

        if (i_accept) begin
            if (i_op == OP_EOF) begin
                // Report where the file stopped, then start over
                if (r_phase inside {[PH_RIFF:PH_EXT]}) begin
                    o_push   = 1'b1;
                    o_result = make_error(ERR_HDR_TRUNC);
                end else if (r_phase inside {[PH_CHUNK_ID:PH_SKIP_BODY]}) begin
                    o_push   = 1'b1;
                    o_result = make_error(ERR_NO_DATA);
                end else if (r_phase == PH_DATA) begin
                    o_push   = 1'b1;
                    o_result = make_error(ERR_DATA_TRUNC);
                end
                n_phase   = PH_RIFF;
                n_cnt     = '0;
                n_shift   = '0;
                n_fmt_len = '0;
                n_chan    = '0;
                n_bits    = '0;
                n_rate    = '0;
                n_remain  = '0;
            end else begin
                case (r_phase)
                    PH_RIFF: begin
                        if (r_cnt < 4'd4 && i_byte != riff_byte(idx)) begin
                            n_phase  = PH_FAILED;
                            o_push   = 1'b1;
                            o_result = make_error(ERR_NOT_RIFF);
                        end else if (r_cnt == 4'd11) begin
                            n_phase = PH_FMT_MAGIC;
                            n_cnt   = '0;
                            n_shift = '0;
                        end else begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                    PH_FMT_MAGIC: begin
                        if (i_byte != fmt_byte(idx)) begin
                            n_phase  = PH_FAILED;
                            o_push   = 1'b1;
                            o_result = make_error(ERR_BAD_FMT);
                        end else if (r_cnt == 4'd3) begin
                            n_phase = PH_FMT_SIZE;
                            n_cnt   = '0;
                            n_shift = '0;
                        end else begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                    PH_FMT_SIZE: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd3) begin
                            n_fmt_len = shifted;
                            n_phase   = PH_TAG;
                            n_cnt     = '0;
                            n_shift   = '0;
                        end
                    end
                    PH_TAG: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd1) begin
                            n_cnt = '0;
                            if (shifted != PCM_TAG) begin
                                n_phase  = PH_FAILED;
                                o_push   = 1'b1;
                                o_result = make_error(ERR_NOT_PCM);
                            end else begin
                                n_phase = PH_CHANNELS;
                                n_shift = '0;
                            end
                        end
                    end
                    PH_CHANNELS: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd1) begin
                            n_chan  = shifted[HALF_W-1:0];
                            n_phase = PH_RATE;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                    PH_RATE: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd3) begin
                            n_rate  = shifted;
                            n_phase = PH_SKIP6;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                    PH_SKIP6: begin
                        if (r_cnt == 4'd5) begin
                            n_phase = PH_BITS;
                            n_cnt   = '0;
                            n_shift = '0;
                        end else begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                    PH_BITS: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd1) begin
                            n_bits = shifted[HALF_W-1:0];
                            n_cnt  = '0;
                            if (bad_format) begin
                                n_phase  = PH_FAILED;
                                o_push   = 1'b1;
                                o_result = make_error(ERR_UNSUPPORTED);
                            end else if (r_fmt_len > FMT_BASE_LEN) begin
                                n_remain = r_fmt_len - FMT_BASE_LEN;
                                n_phase  = PH_EXT;
                                n_shift  = '0;
                            end else begin
                                n_phase = PH_CHUNK_ID;
                                n_shift = '0;
                            end
                        end
                    end
                    PH_EXT, PH_SKIP_BODY: begin
                        n_remain = remain_dec;
                        if (remain_last) begin
                            n_phase = PH_CHUNK_ID;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                    PH_CHUNK_ID: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd3) begin
                            n_phase = (shifted == DATA_ID) ? PH_SIZE_DATA : PH_SIZE_OTHER;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                    PH_SIZE_OTHER: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd3) begin
                            n_remain = shifted;
                            n_phase  = (shifted == '0) ? PH_CHUNK_ID : PH_SKIP_BODY;
                            n_cnt    = '0;
                            n_shift  = '0;
                        end
                    end
                    PH_SIZE_DATA: begin
                        n_shift = shifted;
                        n_cnt   = cnt_take;
                        if (idx == 2'd3) begin
                            // Emit the format descriptor
                            o_push                 = 1'b1;
                            o_result.kind          = KIND_FORMAT;
                            o_result.sample_format = {r_bits == DEPTH_16,
                                                      r_chan == CHAN_STEREO};
                            o_result.sample_rate   = r_rate;
                            o_result.data_length   = shifted;
                            n_remain = shifted;
                            n_phase  = (shifted == '0) ? PH_DONE : PH_DATA;
                            n_cnt    = '0;
                            n_shift  = '0;
                        end
                    end
                    PH_DATA: begin
                        // Pass the payload byte through
                        o_push              = 1'b1;
                        o_result.kind       = KIND_DATA;
                        o_result.audio_byte = i_byte;
                        o_result.is_last    = remain_last;
                        n_remain = remain_dec;
                        if (remain_last) begin
                            n_phase = PH_DONE;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                    default: begin
                        // Done or failed: drop bytes until end of file
                    end
                endcase
            end
        end
    end

endmodule

/* hw/rtl/whp_queue.sv */
// ----------------------------------------------------------------------------
// whp_queue
// Small result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module whp_queue #(
    parameter int DEPTH = whp_pkg::WHP_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  whp_pkg::t_result i_data,
    input  logic             i_pop,
    output whp_pkg::t_result o_data,
    output whp_pkg::t_q_stat o_stat
);
    import whp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_count == CNT_W'(DEPTH));
        o_stat.empty = (r_count == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_data       = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/whp_back.sv */
// ----------------------------------------------------------------------------
// whp_back
// Output register: pulls results from the queue and holds them for the sink.
// ----------------------------------------------------------------------------
module whp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  whp_pkg::t_q_stat i_q_stat,
    input  whp_pkg::t_result i_q_data,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output whp_pkg::t_result o_result
);
    import whp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    // Load when the register is free or being emptied this cycle
    always_comb begin
        o_pop   = !i_q_stat.empty && (!r_valid || i_ready);
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/wav_header_parser.sv */
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE PCM header parser with audio payload pass-through.
// ----------------------------------------------------------------------------
// Slave stream: one file byte per transfer on tdata, tuser = 1 marks end of
// file (tdata ignored) and returns the parser to its reset state.
// Master stream: zero or one result per input transfer. tuser gives the kind
// (format descriptor, audio byte, error), tlast marks the final audio byte.
// Throughput: one input byte per clock while the queue is not full; the parser
// decides each byte in the cycle it is taken, with no per-item iteration.
// Path: a result is written into the queue when its input transfer is taken
// and is then loaded from the queue into the output register, which drives
// tvalid; while that register holds an untaken result, later ones wait in
// the queue.
// Stall: results wait in the queue (QUEUE_DEPTH entries) plus the output
// register; tready on the slave side drops only when the queue is full.
// Errors are reported once; later bytes are dropped until end of file.
// Reset: synchronous, active low; clears phase, counters and the queue, and
// the block takes input as soon as reset is released.
// ----------------------------------------------------------------------------
module wav_header_parser #(
    parameter int QUEUE_DEPTH = whp_pkg::WHP_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [whp_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // [7:0] file_byte
    input  logic                            i_s_axis_tuser,  // [0] operation
    // Master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [1:0] sample_format, [33:2] sample_rate, [65:34] data_length,
    // [73:66] audio_byte, [76:74] error_code, [79:77] zero
    output logic [whp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [whp_pkg::KIND_W-1:0]      o_m_axis_tuser,  // [1:0] kind
    output logic                            o_m_axis_tlast   // is_last
);
    import whp_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    t_result    front_result;
    t_result    q_data;
    t_q_stat    q_stat;
    logic       out_valid;
    t_result    out_result;
    t_out_tdata out_tdata;

    assign o_s_axis_tready = !q_stat.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    whp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_s_axis_tuser),
        .i_byte   (i_s_axis_tdata),
        .o_push   (push),
        .o_result (front_result)
    );

    whp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_result),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    whp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (q_data),
        .o_pop    (pop),
        .i_ready  (i_m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    // Pack the master payload
    always_comb begin
        out_tdata               = '0;
        out_tdata.sample_format = out_result.sample_format;
        out_tdata.sample_rate   = out_result.sample_rate;
        out_tdata.data_length   = out_result.data_length;
        out_tdata.audio_byte    = out_result.audio_byte;
        out_tdata.error_code    = out_result.error_code;
    end

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = out_tdata;
    assign o_m_axis_tuser  = out_result.kind;
    assign o_m_axis_tlast  = out_result.is_last;

endmodule

/* hw/rtl/whp_checker.sv */
// ----------------------------------------------------------------------------
// whp_checker
// Port-level checks on the WAV header parser output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [whp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [whp_pkg::KIND_W-1:0]      o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);
    import whp_pkg::*;

    t_out_tdata m_data;

    assign m_data = o_m_axis_tdata;

    // A stalled result holds until taken
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid &&
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast)),
        "output changed while stalled")

    // Only audio bytes carry tlast
    `ASSERT_CLK(a_last_on_data, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser == KIND_DATA),
        "tlast on a non-data result")

    // Error results carry only their code
    `ASSERT_CLK(a_error_clean, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_ERROR) |->
            (m_data.sample_rate == '0 && m_data.data_length == '0 &&
             m_data.audio_byte == '0 && m_data.sample_format == '0 && !o_m_axis_tlast),
        "error result with payload")

    // No result right after reset
    `ASSERT_CLK_ALWAYS(a_reset_quiet, i_clk,
        $past(!i_rst_n) |-> !o_m_axis_tvalid,
        "output valid after reset")

endmodule

bind wav_header_parser whp_checker u_whp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
